// File: rtl/core/tot_pkg.sv
`default_nettype none
package tot_pkg;
   localparam int TAPS = 31;
   localparam int COEF_WIDTH = 16;
   localparam int AXES = 3;
   localparam int TABLE_LEN = 31;
   localparam int TAP_IDX_W = (TAPS > 1) ? $clog2(TAPS) : 1;
   localparam int AXIS_IDX_W = (AXES > 1) ? $clog2(AXES) : 1;
   localparam int ACC_W = 48;

   localparam logic [0:0] REG_SWING_THRESHOLD = 1'b0;
   localparam logic [0:0] REG_STALE_TIMEOUT = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_MAC,
      ST_ROUND,
      ST_TRACK,
      ST_NEXT,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic tick_inc;
      logic shift;
      logic acc_clear;
      logic mac;
      logic round;
      logic track;
      logic load_out;
      logic [AXIS_IDX_W-1:0] axis;
      logic [TAP_IDX_W-1:0] tap;
   } cmd_type;

   function automatic logic [COEF_WIDTH-1:0] coef_at(input int n);
      logic [63:0] e12;
      int k;
      logic [127:0] p;
      e12 = 64'd0;
      k = (n < 16) ? n : (TABLE_LEN - 1 - n);
      if (n < 0 || n >= TABLE_LEN) return '0;
      case (k)
         0: e12 = 64'd21395026598;
         1: e12 = 64'd22735500344;
         2: e12 = 64'd24115319317;
         3: e12 = 64'd25533599101;
         4: e12 = 64'd26989312673;
         5: e12 = 64'd28481289457;
         6: e12 = 64'd30008208454;
         7: e12 = 64'd31568597835;
         8: e12 = 64'd33160828636;
         9: e12 = 64'd34783114994;
         10: e12 = 64'd36433508516;
         11: e12 = 64'd38109899252;
         12: e12 = 64'd39810010843;
         13: e12 = 64'd41531402341;
         14: e12 = 64'd43271464239;
         15: e12 = 64'd44145834799;
         default: e12 = 64'd0;
      endcase
      p = ({64'd0, e12} << COEF_WIDTH) + 128'd500000000000;
      p = p / 128'd1000000000000;
      return p[COEF_WIDTH-1:0];
   endfunction
endpackage
`default_nettype wire

// File: rtl/core/tot_if.sv
`default_nettype none
interface tot_req_if;
   logic valid;
   logic ready;
   logic signed [15:0] angle_roll;
   logic signed [15:0] angle_pitch;
   logic signed [15:0] angle_yaw;
   modport source(output valid, angle_roll, angle_pitch, angle_yaw, input ready);
   modport sink(input valid, angle_roll, angle_pitch, angle_yaw, output ready);
endinterface

interface tot_rsp_if;
   logic valid;
   logic ready;
   logic signed [15:0] filt_roll, filt_pitch, filt_yaw;
   logic signed [15:0] center_roll, center_pitch, center_yaw;
   logic [14:0] amp_roll, amp_pitch, amp_yaw;
   logic [15:0] period_roll, period_pitch, period_yaw;
   modport source(output valid, filt_roll, filt_pitch, filt_yaw, center_roll, center_pitch,
      center_yaw, amp_roll, amp_pitch, amp_yaw, period_roll, period_pitch, period_yaw,
      input ready);
   modport sink(input valid, filt_roll, filt_pitch, filt_yaw, center_roll, center_pitch,
      center_yaw, amp_roll, amp_pitch, amp_yaw, period_roll, period_pitch, period_yaw,
      output ready);
endinterface

interface tot_csr_if;
   logic valid;
   logic ready;
   logic [0:0] index;
   logic [15:0] data;
   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/tot_ctrl.sv
`default_nettype none
module tot_ctrl (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_fire,
   input  wire logic rsp_busy,
   output tot_pkg::cmd_type cmd,
   output logic idle
);
   tot_pkg::state_type state_ff, state_in;
   logic [tot_pkg::AXIS_IDX_W-1:0] axis_ff, axis_in;
   logic [tot_pkg::TAP_IDX_W-1:0] tap_ff, tap_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tot_pkg::ST_IDLE;
         axis_ff <= '0;
         tap_ff <= '0;
      end else begin
         state_ff <= state_in;
         axis_ff <= axis_in;
         tap_ff <= tap_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      axis_in = axis_ff;
      tap_in = tap_ff;
      cmd = '0;
      cmd.axis = axis_ff;
      cmd.tap = tap_ff;
      idle = 1'b0;
      case (state_ff)
         tot_pkg::ST_IDLE: begin
            idle = !rsp_busy;
            if (req_fire) begin
               cmd.tick_inc = 1'b1;
               axis_in = '0;
               state_in = tot_pkg::ST_SHIFT;
            end
         end
         tot_pkg::ST_SHIFT: begin
            cmd.shift = 1'b1;
            cmd.acc_clear = 1'b1;
            tap_in = '0;
            state_in = tot_pkg::ST_MAC;
         end
         tot_pkg::ST_MAC: begin
            cmd.mac = 1'b1;
            if (tap_ff == tot_pkg::TAP_IDX_W'(tot_pkg::TAPS - 1)) begin
               state_in = tot_pkg::ST_ROUND;
            end else begin
               tap_in = tap_ff + 1'b1;
            end
         end
         tot_pkg::ST_ROUND: begin
            cmd.round = 1'b1;
            state_in = tot_pkg::ST_TRACK;
         end
         tot_pkg::ST_TRACK: begin
            cmd.track = 1'b1;
            state_in = tot_pkg::ST_NEXT;
         end
         tot_pkg::ST_NEXT: begin
            if (axis_ff == tot_pkg::AXIS_IDX_W'(tot_pkg::AXES - 1)) begin
               state_in = tot_pkg::ST_OUT;
            end else begin
               axis_in = axis_ff + 1'b1;
               state_in = tot_pkg::ST_SHIFT;
            end
         end
         tot_pkg::ST_OUT: begin
            if (!rsp_busy) begin
               cmd.load_out = 1'b1;
               state_in = tot_pkg::ST_IDLE;
            end
         end
         default: state_in = tot_pkg::ST_IDLE;
      endcase
   end
endmodule
`default_nettype wire

// File: rtl/core/tot_dp.sv
`default_nettype none
module tot_dp (
   input  wire logic clock,
   input  wire logic reset,
   input  tot_pkg::cmd_type cmd,
   input  wire logic signed [15:0] in_angle [3],
   input  wire logic [14:0] thr,
   input  wire logic [15:0] timeout,
   output logic signed [15:0] filt_o [3],
   output logic signed [15:0] center_o [3],
   output logic [14:0] amp_o [3],
   output logic [15:0] period_o [3]
);
   localparam int A = tot_pkg::AXES;
   localparam int T = tot_pkg::TAPS;

   logic signed [15:0] taps_ff [A][T];
   logic signed [15:0] ang_ff [3];
   logic [31:0] tick_ff;
   logic signed [tot_pkg::ACC_W-1:0] acc_ff;
   logic signed [15:0] y_ff;
   logic signed [15:0] filt_ff [3];
   logic signed [15:0] rpk_ff [A], rtr_ff [A], hpk_ff [A], htr_ff [A];
   logic [31:0] rpkt_ff [A], rtrt_ff [A], pold_ff [A], pnew_ff [A], told_ff [A], tnew_ff [A];
   logic [1:0] pcnt_ff [A], tcnt_ff [A];
   logic armp_ff [A], armt_ff [A];
   logic [15:0] per_ff [A];
   logic signed [15:0] oc_ff [A];
   logic [14:0] oa_ff [A];
   logic [15:0] op_ff [A];

   logic [tot_pkg::COEF_WIDTH-1:0] coef;
   logic signed [15:0] tap_val;
   logic signed [tot_pkg::ACC_W-1:0] prod, rnd;
   logic signed [tot_pkg::ACC_W-1:0] q;

   always_comb begin
      coef = '0;
      for (int n = 0; n < T; n++) begin
         if (cmd.tap == tot_pkg::TAP_IDX_W'(n)) coef = tot_pkg::coef_at(n);
      end
      tap_val = taps_ff[cmd.axis][0];
      prod = tot_pkg::ACC_W'($signed({1'b0, coef}) * tap_val);
      rnd = acc_ff + (tot_pkg::ACC_W'(1) <<< (tot_pkg::COEF_WIDTH - 1));
      q = rnd >>> tot_pkg::COEF_WIDTH;
   end

   always_ff @(posedge clock) begin
      if (cmd.tick_inc) begin
         ang_ff <= in_angle;
      end
      if (cmd.acc_clear) acc_ff <= '0;
      else if (cmd.mac) acc_ff <= acc_ff + prod;
      if (cmd.round) begin
         if (q > 48'sd32767) y_ff <= 16'sh7fff;
         else if (q < -48'sd32768) y_ff <= -16'sh8000;
         else y_ff <= q[15:0];
      end
      if (cmd.load_out) begin
         for (int a = 0; a < 3; a++) begin
            filt_o[a] <= (a < A) ? filt_ff[a] : '0;
            center_o[a] <= (a < A) ? oc_ff[a < A ? a : 0] : '0;
            amp_o[a] <= (a < A) ? oa_ff[a < A ? a : 0] : '0;
            period_o[a] <= (a < A) ? op_ff[a < A ? a : 0] : '0;
         end
      end
      if (reset) begin
         for (int a = 0; a < A; a++) begin
            for (int n = 0; n < T; n++) taps_ff[a][n] <= '0;
         end
         for (int a = 0; a < 3; a++) filt_ff[a] <= '0;
      end else begin
         if (cmd.shift) begin
            for (int n = T - 1; n > 0; n--) taps_ff[cmd.axis][n] <= taps_ff[cmd.axis][n-1];
            taps_ff[cmd.axis][0] <= ang_ff[cmd.axis];
         end else if (cmd.mac) begin
            // rotate the line so the next tap sits at the head
            for (int n = 0; n < T - 1; n++) taps_ff[cmd.axis][n] <= taps_ff[cmd.axis][n+1];
            taps_ff[cmd.axis][T-1] <= taps_ff[cmd.axis][0];
         end
         if (cmd.track) filt_ff[cmd.axis] <= y_ff;
      end
   end

   logic signed [15:0] p_rpk, p_rtr, p_hpk, p_htr;
   logic [31:0] p_rpkt, p_rtrt, p_pold, p_pnew, p_told, p_tnew, d;
   logic [1:0] p_pcnt, p_tcnt;
   logic p_armp, p_armt, stale;
   logic [15:0] p_per;
   logic signed [16:0] sum, dif, thr_s, y17;

   always_comb begin
      p_rpk = rpk_ff[cmd.axis]; p_rtr = rtr_ff[cmd.axis];
      p_hpk = hpk_ff[cmd.axis]; p_htr = htr_ff[cmd.axis];
      p_rpkt = rpkt_ff[cmd.axis]; p_rtrt = rtrt_ff[cmd.axis];
      p_pold = pold_ff[cmd.axis]; p_pnew = pnew_ff[cmd.axis];
      p_told = told_ff[cmd.axis]; p_tnew = tnew_ff[cmd.axis];
      p_pcnt = pcnt_ff[cmd.axis]; p_tcnt = tcnt_ff[cmd.axis];
      p_armp = armp_ff[cmd.axis]; p_armt = armt_ff[cmd.axis];
      p_per = per_ff[cmd.axis];
      thr_s = {2'b00, thr};
      y17 = 17'(y_ff);
      d = '0;
      if (y17 < -thr_s) begin
         if (y_ff < p_rtr) begin p_rtr = y_ff; p_rtrt = tick_ff; end
         if (p_armp) begin
            p_hpk = p_rpk; p_pold = p_pnew; p_pnew = p_rpkt;
            if (p_pcnt != 2'd3) p_pcnt = p_pcnt + 1'b1;
            if (p_pcnt == 2'd3) begin
               d = p_pnew - p_pold;
               p_per = (d > 32'd65535) ? 16'hffff : d[15:0];
            end
         end
         p_rpk = '0; p_armp = 1'b0; p_armt = 1'b1;
      end
      if (y17 > thr_s) begin
         if (y_ff > p_rpk) begin p_rpk = y_ff; p_rpkt = tick_ff; end
         if (p_armt) begin
            p_htr = p_rtr; p_told = p_tnew; p_tnew = p_rtrt;
            if (p_tcnt != 2'd3) p_tcnt = p_tcnt + 1'b1;
            if (p_tcnt == 2'd3) begin
               d = p_tnew - p_told;
               p_per = (d > 32'd65535) ? 16'hffff : d[15:0];
            end
         end
         p_rtr = '0; p_armt = 1'b0; p_armp = 1'b1;
      end
      stale = ((tick_ff - p_told) > {16'd0, timeout}) && ((tick_ff - p_pold) > {16'd0, timeout});
      sum = 17'(p_hpk) + 17'(p_htr);
      dif = 17'(p_hpk) - 17'(p_htr);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff <= '0;
         for (int a = 0; a < A; a++) begin
            rpk_ff[a] <= '0; rtr_ff[a] <= '0; hpk_ff[a] <= '0; htr_ff[a] <= '0;
            rpkt_ff[a] <= '0; rtrt_ff[a] <= '0; pold_ff[a] <= '0; pnew_ff[a] <= '0;
            told_ff[a] <= '0; tnew_ff[a] <= '0; pcnt_ff[a] <= '0; tcnt_ff[a] <= '0;
            armp_ff[a] <= 1'b1; armt_ff[a] <= 1'b1; per_ff[a] <= '0;
            oc_ff[a] <= '0; oa_ff[a] <= '0; op_ff[a] <= '0;
         end
      end else begin
         if (cmd.tick_inc) tick_ff <= tick_ff + 1'b1;
         if (cmd.track) begin
            rpk_ff[cmd.axis] <= p_rpk; rtr_ff[cmd.axis] <= p_rtr;
            hpk_ff[cmd.axis] <= p_hpk; htr_ff[cmd.axis] <= p_htr;
            rpkt_ff[cmd.axis] <= p_rpkt; rtrt_ff[cmd.axis] <= p_rtrt;
            pold_ff[cmd.axis] <= p_pold; pnew_ff[cmd.axis] <= p_pnew;
            told_ff[cmd.axis] <= p_told; tnew_ff[cmd.axis] <= p_tnew;
            pcnt_ff[cmd.axis] <= p_pcnt; tcnt_ff[cmd.axis] <= p_tcnt;
            armp_ff[cmd.axis] <= p_armp; armt_ff[cmd.axis] <= p_armt;
            per_ff[cmd.axis] <= p_per;
            if (p_pcnt == 2'd3 || p_tcnt == 2'd3) begin
               oc_ff[cmd.axis] <= stale ? 16'sd0 : sum[16:1];
               oa_ff[cmd.axis] <= (stale || dif[16]) ? 15'd0 : dif[15:1];
               op_ff[cmd.axis] <= stale ? 16'd0 : p_per;
            end
         end
      end
   end
endmodule
`default_nettype wire

// File: rtl/core/tilt_oscillation_tracker_core.sv
`default_nettype none
// Three-axis tilt swing tracker: each tick (one req beat) runs a 31-tap symmetric
// low-pass FIR per axis on one shared multiply-accumulate unit, then a hysteresis
// swing tracker; one rsp beat carries filtered angles, swing center, half amplitude
// and period. The single MAC steps through every tap of each axis in turn, and
// no new req is taken until the rsp beat is loaded. Write csr only while idle.
module tilt_oscillation_tracker_core (
   input wire logic clock,
   input wire logic reset,
   tot_req_if.sink req,
   tot_rsp_if.source rsp,
   tot_csr_if.sink csr
);
   tot_pkg::cmd_type cmd;
   logic idle, rsp_valid_ff;
   logic [14:0] thr_ff;
   logic [15:0] tmo_ff;
   logic signed [15:0] ang [3];
   logic signed [15:0] filt [3], cen [3];
   logic [14:0] amp [3];
   logic [15:0] per [3];

   assign req.ready = idle;
   assign csr.ready = 1'b1;
   assign ang[0] = req.angle_roll;
   assign ang[1] = req.angle_pitch;
   assign ang[2] = req.angle_yaw;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= 15'd64;
         tmo_ff <= 16'd6250;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr.valid && csr.index == tot_pkg::REG_SWING_THRESHOLD) thr_ff <= csr.data[14:0];
         if (csr.valid && csr.index == tot_pkg::REG_STALE_TIMEOUT) tmo_ff <= csr.data;
         if (cmd.load_out) rsp_valid_ff <= 1'b1;
         else if (rsp.ready) rsp_valid_ff <= 1'b0;
      end
   end

   tot_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_fire(req.valid && idle),
      .rsp_busy(rsp_valid_ff && !rsp.ready), .cmd(cmd), .idle(idle)
   );

   tot_dp u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .in_angle(ang), .thr(thr_ff),
      .timeout(tmo_ff), .filt_o(filt), .center_o(cen), .amp_o(amp), .period_o(per)
   );

   assign rsp.valid = rsp_valid_ff;
   assign rsp.filt_roll = filt[0];
   assign rsp.filt_pitch = filt[1];
   assign rsp.filt_yaw = filt[2];
   assign rsp.center_roll = cen[0];
   assign rsp.center_pitch = cen[1];
   assign rsp.center_yaw = cen[2];
   assign rsp.amp_roll = amp[0];
   assign rsp.amp_pitch = amp[1];
   assign rsp.amp_yaw = amp[2];
   assign rsp.period_roll = per[0];
   assign rsp.period_pitch = per[1];
   assign rsp.period_yaw = per[2];
endmodule
`default_nettype wire
